/* rtl/bvm_pkg.sv */
// Package for the byte VM instruction executor: widths, opcode field codes,
// status codes and the execute result struct. Depends on nothing.
package bvm_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SI_W        = $clog2(STACK_DEPTH);

  localparam int unsigned ADDR_W = 12;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OP_W   = 16;

  localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
  localparam logic [ADDR_W-1:0] PC_STEP  = 12'd2;
  localparam logic [3:0]        FLAG_REG = 4'hF;

  // top nibble of the instruction
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SEQI  = 4'h3;
  localparam logic [3:0] GRP_SNEI  = 4'h4;
  localparam logic [3:0] GRP_SEQR  = 4'h5;
  localparam logic [3:0] GRP_LDI   = 4'h6;
  localparam logic [3:0] GRP_ADDI  = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNER  = 4'h9;
  localparam logic [3:0] GRP_SETI  = 4'hA;
  localparam logic [3:0] GRP_JPV0  = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;

  // whole-word system instructions
  localparam logic [OP_W-1:0] OP_CLS = 16'h00E0;
  localparam logic [OP_W-1:0] OP_RET = 16'h00EE;

  // ALU selector in the low nibble
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_OVERFLOW    = 2'd2,
    ST_UNDERFLOW   = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] ret_addr;
    logic              idx_we;
    logic [ADDR_W-1:0] idx;
    logic              wr;
    logic [3:0]        reg_num;
    logic [BYTE_W-1:0] res;
    logic              fw;
    logic              flag;
    logic              cls;
    logic              push;
    logic              pop;
    status_t           status;
  } exec_t;

endpackage

/* rtl/bvm_in_if.sv */
// Instruction input channel: valid/ready handshake with opcode and random byte.
// Depends on bvm_pkg.
interface bvm_in_if import bvm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] random_byte;

  modport source (output valid, opcode, random_byte, input ready);
  modport sink   (input valid, opcode, random_byte, output ready);
endinterface

/* rtl/bvm_out_if.sv */
// Result channel: valid/ready handshake carrying the architectural effects of
// one instruction. Depends on bvm_pkg.
interface bvm_out_if import bvm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] next_pc;
  logic [ADDR_W-1:0] index_value;
  logic              reg_written;
  logic [3:0]        reg_number;
  logic [BYTE_W-1:0] reg_value;
  logic              flag_written;
  logic              flag_value;
  logic              clear_screen;
  logic [1:0]        status;

  modport source (output valid, next_pc, index_value, reg_written, reg_number,
                  reg_value, flag_written, flag_value, clear_screen, status,
                  input ready);
  modport sink   (input valid, next_pc, index_value, reg_written, reg_number,
                  reg_value, flag_written, flag_value, clear_screen, status,
                  output ready);
endinterface

/* rtl/bvm_exec.sv */
// Combinational decode and execute of one instruction against given operands.
// Depends on bvm_pkg.
module bvm_exec import bvm_pkg::*; (
  input  logic [OP_W-1:0]   opcode,
  input  logic [BYTE_W-1:0] random_byte,
  input  logic [BYTE_W-1:0] vx,
  input  logic [BYTE_W-1:0] vy,
  input  logic [BYTE_W-1:0] v0,
  input  logic [ADDR_W-1:0] pc,
  input  logic [ADDR_W-1:0] index_cur,
  input  logic [SP_W-1:0]   sp,
  input  logic [ADDR_W-1:0] stack_top,
  output exec_t             ex
);

  logic [3:0]        grp;
  logic [3:0]        rx;
  logic [3:0]        nib;
  logic [BYTE_W-1:0] kk;
  logic [ADDR_W-1:0] nnn;
  logic [ADDR_W-1:0] pc_inc;
  logic [ADDR_W-1:0] pc_skip;
  logic [BYTE_W:0]   sum;
  logic [BYTE_W:0]   dxy;
  logic [BYTE_W:0]   dyx;

  assign grp     = opcode[15:12];
  assign rx      = opcode[11:8];
  assign nib     = opcode[3:0];
  assign kk      = opcode[7:0];
  assign nnn     = opcode[11:0];
  assign pc_inc  = pc + PC_STEP;
  assign pc_skip = pc_inc + PC_STEP;
  assign sum     = {1'b0, vx} + {1'b0, vy};
  assign dxy     = {1'b0, vx} - {1'b0, vy};
  assign dyx     = {1'b0, vy} - {1'b0, vx};

  always_comb begin
    ex          = '0;
    ex.next_pc  = pc_inc;
    ex.ret_addr = pc_inc;
    ex.idx      = index_cur;
    ex.status   = ST_OK;
    case (grp)
      GRP_SYS: begin
        if (opcode == OP_CLS) begin
          ex.cls = 1'b1;
        end else if (opcode == OP_RET) begin
          if (sp == '0) begin
            ex.status  = ST_UNDERFLOW;
            ex.next_pc = pc;
          end else begin
            ex.pop     = 1'b1;
            ex.next_pc = stack_top;
          end
        end else begin
          ex.status = ST_UNSUPPORTED;
        end
      end
      GRP_JP:   ex.next_pc = nnn;
      GRP_CALL: begin
        if (sp == SP_W'(STACK_DEPTH)) begin
          ex.status  = ST_OVERFLOW;
          ex.next_pc = pc;
        end else begin
          ex.push    = 1'b1;
          ex.next_pc = nnn;
        end
      end
      GRP_SEQI: if (vx == kk) ex.next_pc = pc_skip;
      GRP_SNEI: if (vx != kk) ex.next_pc = pc_skip;
      GRP_SEQR: begin
        if (nib != 4'h0) ex.status = ST_UNSUPPORTED;
        else if (vx == vy) ex.next_pc = pc_skip;
      end
      GRP_SNER: begin
        if (nib != 4'h0) ex.status = ST_UNSUPPORTED;
        else if (vx != vy) ex.next_pc = pc_skip;
      end
      GRP_LDI: begin
        ex.wr  = 1'b1;
        ex.res = kk;
      end
      GRP_ADDI: begin
        ex.wr  = 1'b1;
        ex.res = vx + kk;
      end
      GRP_ALU: begin
        ex.wr = 1'b1;
        case (nib)
          ALU_MOV: ex.res = vy;
          ALU_OR:  ex.res = vx | vy;
          ALU_AND: ex.res = vx & vy;
          ALU_XOR: ex.res = vx ^ vy;
          ALU_ADD: begin
            ex.fw   = 1'b1;
            ex.flag = sum[BYTE_W];
            ex.res  = sum[BYTE_W-1:0];
          end
          ALU_SUB: begin
            ex.fw   = 1'b1;
            ex.flag = ~dxy[BYTE_W];
            ex.res  = dxy[BYTE_W-1:0];
          end
          ALU_SHR: begin
            ex.fw   = 1'b1;
            ex.flag = vx[0];
            ex.res  = {1'b0, vx[BYTE_W-1:1]};
          end
          ALU_SBN: begin
            ex.fw   = 1'b1;
            ex.flag = ~dyx[BYTE_W];
            ex.res  = dyx[BYTE_W-1:0];
          end
          ALU_SHL: begin
            ex.fw   = 1'b1;
            ex.flag = vx[BYTE_W-1];
            ex.res  = {vx[BYTE_W-2:0], 1'b0};
          end
          default: begin
            ex.wr     = 1'b0;
            ex.status = ST_UNSUPPORTED;
          end
        endcase
      end
      GRP_SETI: begin
        ex.idx_we = 1'b1;
        ex.idx    = nnn;
      end
      GRP_JPV0: ex.next_pc = nnn + {{(ADDR_W-BYTE_W){1'b0}}, v0};
      GRP_RND: begin
        ex.wr  = 1'b1;
        ex.res = random_byte & kk;
      end
      default: ex.status = ST_UNSUPPORTED;
    endcase
    ex.reg_num = ex.wr ? rx : 4'h0;
  end

endmodule

/* rtl/byte_vm_instruction_executor.sv */
// Top level of the byte VM instruction executor: input register, register
// file, return stack, execute unit and result register.
// Depends on bvm_pkg, bvm_in_if, bvm_out_if and bvm_exec.
//
// Each accepted word passes the input register, then the result register.
// Throughput: one instruction per cycle; the execute stage retires into the
// result register each cycle the result register is empty or being drained.
// Reset (rst_n low, synchronous): PC to 0x200, index, depth and all general
// registers to zero; the return stack keeps whatever it holds.
module byte_vm_instruction_executor import bvm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bvm_in_if.sink            in_chan,
  bvm_out_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Architectural state
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] pc_r;
  logic [ADDR_W-1:0] index_r;
  logic [SP_W-1:0]   sp_r;
  logic [BYTE_W-1:0] vf_r;      // register 15 lives in flops: flags land here
  logic [BYTE_W-1:0] v0_r;      // copy of register 0 for the jump-plus-V0 form
  logic [15:0]       gvld_r;    // register has been written since reset

  logic [BYTE_W-1:0] gpr_mem [16];
  logic [ADDR_W-1:0] stack_r [STACK_DEPTH];

  // ---------------------------------------------------------------------------
  // Execute stage (input register)
  // ---------------------------------------------------------------------------
  logic              s1_valid_r;
  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] rnd_r;
  logic [BYTE_W-1:0] qx_r, qy_r;        // registered register-file reads
  logic              vldx_r, vldy_r;
  logic              bypx_r, bypy_r;    // read collided with a retiring write
  logic [BYTE_W-1:0] bypv_r;

  logic              accept;
  logic              s1_adv;
  logic [3:0]        ax, ay;
  logic [BYTE_W-1:0] vx, vy;
  logic [SI_W-1:0]   top_idx;
  exec_t             ex;

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic              out_valid_r;
  exec_t             res_r;
  logic [ADDR_W-1:0] res_idx_r;

  // Advance the execute stage whenever the result register can take a word;
  // take a new input word whenever the execute stage empties or advances.
  assign s1_adv         = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign accept         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = !s1_valid_r || s1_adv;

  assign ax = in_chan.opcode[11:8];
  assign ay = in_chan.opcode[7:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture the word and read both operands at acceptance. The word ahead in
  // the execute stage retires on the same edge, so forward its result when it
  // writes the register being read.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.opcode;
      rnd_r  <= in_chan.random_byte;
      qx_r   <= gpr_mem[ax];
      qy_r   <= gpr_mem[ay];
      vldx_r <= gvld_r[ax];
      vldy_r <= gvld_r[ay];
      bypx_r <= s1_adv && ex.wr && (ex.reg_num == ax);
      bypy_r <= s1_adv && ex.wr && (ex.reg_num == ay);
      bypv_r <= ex.res;
    end
  end

  // Register 15 always comes from its own flops, which already hold the
  // retired flag or result; others come from the file, the bypass or zero.
  always_comb begin
    if (op_r[11:8] == FLAG_REG) vx = vf_r;
    else if (bypx_r)            vx = bypv_r;
    else if (vldx_r)            vx = qx_r;
    else                        vx = '0;
    if (op_r[7:4] == FLAG_REG)  vy = vf_r;
    else if (bypy_r)            vy = bypv_r;
    else if (vldy_r)            vy = qy_r;
    else                        vy = '0;
  end

  assign top_idx = SI_W'(sp_r - SP_W'(1));

  bvm_exec u_exec (
    .opcode      (op_r),
    .random_byte (rnd_r),
    .vx          (vx),
    .vy          (vy),
    .v0          (v0_r),
    .pc          (pc_r),
    .index_cur   (index_r),
    .sp          (sp_r),
    .stack_top   (stack_r[top_idx]),
    .ex          (ex)
  );

  // ---------------------------------------------------------------------------
  // Retire: update state on the edge the word leaves the execute stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= PC_RESET;
      index_r <= '0;
      sp_r    <= '0;
      vf_r    <= '0;
      v0_r    <= '0;
      gvld_r  <= '0;
    end else if (cfg_we) begin
      // Start address write: load the PC at once
      pc_r <= cfg_wdata;
    end else if (s1_adv) begin
      pc_r <= ex.next_pc;
      if (ex.idx_we) index_r <= ex.idx;
      if (ex.push)   sp_r    <= sp_r + SP_W'(1);
      else if (ex.pop) sp_r  <= sp_r - SP_W'(1);
      // Result wins over the flag when the destination is register 15
      if (ex.wr && ex.reg_num == FLAG_REG) vf_r <= ex.res;
      else if (ex.fw) vf_r <= {{(BYTE_W-1){1'b0}}, ex.flag};
      if (ex.wr && ex.reg_num == 4'h0) v0_r <= ex.res;
      if (ex.wr) gvld_r[ex.reg_num] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && ex.wr) begin
      gpr_mem[ex.reg_num] <= ex.res;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && ex.push) begin
      stack_r[sp_r[SI_W-1:0]] <= ex.ret_addr;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold until the sink takes the word
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r     <= ex;
      res_idx_r <= ex.idx_we ? ex.idx : index_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.next_pc      = res_r.next_pc;
  assign out_chan.index_value  = res_idx_r;
  assign out_chan.reg_written  = res_r.wr;
  assign out_chan.reg_number   = res_r.reg_num;
  assign out_chan.reg_value    = res_r.wr ? res_r.res : '0;
  assign out_chan.flag_written = res_r.fw;
  assign out_chan.flag_value   = res_r.fw & res_r.flag;
  assign out_chan.clear_screen = res_r.cls;
  assign out_chan.status       = res_r.status;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("return stack depth beyond capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && ex.status == ST_OVERFLOW |-> sp_r == SP_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && ex.push && !cfg_we |=> sp_r == $past(sp_r) + SP_W'(1))
    else $error("call did not deepen the stack by one");

  a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("retired word missing from the result register");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for byte_vm_instruction_executor: drives instruction
// words, predicts each result word and compares field by field.
// Depends on bvm_pkg, bvm_in_if, bvm_out_if and the executor RTL.
module tb_top;
  import bvm_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int RESET_CYCLES   = 4;
  // settling margin after the last result, used whenever the block must be idle
  localparam int DRAIN_CYCLES   = 4;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int HOLD_WORDS     = 30;
  localparam int STEADY_WORDS   = 200;
  localparam int REPORT_LIMIT   = 10;

  // groups and selectors the executor does not implement
  localparam logic [3:0] GRP_DRAW = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;
  localparam logic [3:0] ALU_BAD  = 4'h8;

  // architectural effects of one instruction, as seen on the result channel
  typedef struct packed {
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] index_value;
    logic              reg_written;
    logic [3:0]        reg_number;
    logic [BYTE_W-1:0] reg_value;
    logic              flag_written;
    logic              flag_value;
    logic              clear_screen;
    status_t           status;
  } vm_effect_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  bvm_in_if  in_if ();
  bvm_out_if out_if ();

  byte_vm_instruction_executor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow machine state, advanced once per accepted instruction word
  logic [BYTE_W-1:0] vm_gp [16];
  logic [ADDR_W-1:0] vm_index;
  logic [ADDR_W-1:0] vm_pc;
  logic [ADDR_W-1:0] vm_stack [STACK_DEPTH];
  logic [SP_W-1:0]   vm_depth;

  vm_effect_t pending_effects [$];
  int         mismatch_count;
  int         words_checked;
  int         quiet_cycles;
  bit         gaps_enabled;
  bit         hold_req;

  always #HALF_PERIOD clk = ~clk;

  // Execute one instruction on the shadow state and return its effects.
  // The PC is advanced by two first; stack faults keep the PC where it was.
  task automatic execute_instruction(input logic [OP_W-1:0] op,
                                     input logic [BYTE_W-1:0] rnd,
                                     output vm_effect_t eff);
    logic [3:0]        grp, x, y, n;
    logic [BYTE_W-1:0] kk, vx, vy, res;
    logic [ADDR_W-1:0] nnn, pc;
    logic [BYTE_W:0]   sum;
    logic              wr, fw, flag, keep_pc;
    grp = op[15:12];
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    kk  = op[7:0];
    nnn = op[11:0];
    vx  = vm_gp[x];
    vy  = vm_gp[y];
    pc  = vm_pc + PC_STEP;
    eff = '0;
    eff.status = ST_OK;
    wr = 1'b0;
    fw = 1'b0;
    flag = 1'b0;
    res = '0;
    keep_pc = 1'b0;
    case (grp)
      GRP_SYS: begin
        if (op == OP_CLS) begin
          eff.clear_screen = 1'b1;
        end else if (op == OP_RET) begin
          if (vm_depth == '0) begin
            eff.status = ST_UNDERFLOW;
            keep_pc = 1'b1;
          end else begin
            vm_depth = vm_depth - SP_W'(1);
            pc = vm_stack[vm_depth[SI_W-1:0]];
          end
        end else begin
          eff.status = ST_UNSUPPORTED;
        end
      end
      GRP_JP: pc = nnn;
      GRP_CALL: begin
        if (vm_depth >= SP_W'(STACK_DEPTH)) begin
          eff.status = ST_OVERFLOW;
          keep_pc = 1'b1;
        end else begin
          vm_stack[vm_depth[SI_W-1:0]] = pc;
          vm_depth = vm_depth + SP_W'(1);
          pc = nnn;
        end
      end
      GRP_SEQI: if (vx == kk) pc = pc + PC_STEP;
      GRP_SNEI: if (vx != kk) pc = pc + PC_STEP;
      GRP_SEQR: begin
        if (n != 4'h0) eff.status = ST_UNSUPPORTED;
        else if (vx == vy) pc = pc + PC_STEP;
      end
      GRP_LDI: begin
        wr = 1'b1;
        res = kk;
      end
      GRP_ADDI: begin
        wr = 1'b1;
        res = vx + kk;
      end
      GRP_ALU: begin
        wr = 1'b1;
        case (n)
          ALU_MOV: res = vy;
          ALU_OR:  res = vx | vy;
          ALU_AND: res = vx & vy;
          ALU_XOR: res = vx ^ vy;
          ALU_ADD: begin
            sum = {1'b0, vx} + {1'b0, vy};
            fw = 1'b1;
            flag = sum[BYTE_W];
            res = sum[BYTE_W-1:0];
          end
          ALU_SUB: begin
            fw = 1'b1;
            flag = (vx >= vy);
            res = vx - vy;
          end
          ALU_SHR: begin
            fw = 1'b1;
            flag = vx[0];
            res = vx >> 1;
          end
          ALU_SBN: begin
            fw = 1'b1;
            flag = (vy >= vx);
            res = vy - vx;
          end
          ALU_SHL: begin
            fw = 1'b1;
            flag = vx[BYTE_W-1];
            res = vx << 1;
          end
          default: begin
            wr = 1'b0;
            eff.status = ST_UNSUPPORTED;
          end
        endcase
      end
      GRP_SNER: begin
        if (n != 4'h0) eff.status = ST_UNSUPPORTED;
        else if (vx != vy) pc = pc + PC_STEP;
      end
      GRP_SETI: vm_index = nnn;
      GRP_JPV0: pc = nnn + {4'h0, vm_gp[0]};
      GRP_RND: begin
        wr = 1'b1;
        res = rnd & kk;
      end
      default: eff.status = ST_UNSUPPORTED;
    endcase
    // flag first, result second: with x = 15 the result is what remains
    if (fw) vm_gp[FLAG_REG] = {7'b0, flag};
    if (wr) vm_gp[x] = res;
    if (!keep_pc) vm_pc = pc;
    eff.next_pc      = vm_pc;
    eff.index_value  = vm_index;
    eff.reg_written  = wr;
    eff.reg_number   = wr ? x : 4'h0;
    eff.reg_value    = wr ? res : '0;
    eff.flag_written = fw;
    eff.flag_value   = fw ? flag : 1'b0;
  endtask

  // Draw a mostly well-formed instruction; skip operands often match the
  // shadow registers so that both outcomes of every skip occur.
  function automatic logic [OP_W-1:0] pick_instruction();
    logic [3:0]        x, y, sel;
    logic [BYTE_W-1:0] kk;
    logic [ADDR_W-1:0] nnn;
    int unsigned       roll;
    x    = 4'($urandom_range(0, 15));
    y    = 4'($urandom_range(0, 15));
    kk   = 8'($urandom_range(0, 255));
    nnn  = 12'($urandom_range(0, 4095));
    roll = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0: sel = ALU_MOV;
      1: sel = ALU_OR;
      2: sel = ALU_AND;
      3: sel = ALU_XOR;
      4: sel = ALU_ADD;
      5: sel = ALU_SUB;
      6: sel = ALU_SHR;
      7: sel = ALU_SBN;
      8: sel = ALU_SHL;
      default: sel = 4'($urandom_range(0, 15));
    endcase
    if (roll < 5) return 16'($urandom_range(0, 65535));
    else if (roll < 9) return OP_CLS;
    else if (roll < 16) return OP_RET;
    else if (roll < 23) return {GRP_CALL, nnn};
    else if (roll < 27) return {GRP_JP, nnn};
    else if (roll < 31)
      return {($urandom_range(0, 1) ? GRP_SEQI : GRP_SNEI), x,
              ($urandom_range(0, 1) ? vm_gp[x] : kk)};
    else if (roll < 35)
      return {($urandom_range(0, 1) ? GRP_SEQR : GRP_SNER), x,
              ($urandom_range(0, 1) ? x : y),
              ($urandom_range(0, 7) == 0 ? 4'($urandom_range(1, 15)) : 4'h0)};
    else if (roll < 45) return {GRP_LDI, x, kk};
    else if (roll < 52) return {GRP_ADDI, x, kk};
    else if (roll < 80) return {GRP_ALU, x, y, sel};
    else if (roll < 85) return {GRP_SETI, nnn};
    else if (roll < 88) return {GRP_JPV0, nnn};
    else if (roll < 93) return {GRP_RND, x, kk};
    else return {4'($urandom_range(GRP_DRAW, GRP_MISC)), 12'($urandom)};
  endfunction

  function automatic string field_diff(vm_effect_t want, vm_effect_t got);
    string s;
    s = "";
    if (got.next_pc !== want.next_pc) s = {s, " next_pc"};
    if (got.index_value !== want.index_value) s = {s, " index_value"};
    if (got.reg_written !== want.reg_written) s = {s, " reg_written"};
    if (got.reg_number !== want.reg_number) s = {s, " reg_number"};
    if (got.reg_value !== want.reg_value) s = {s, " reg_value"};
    if (got.flag_written !== want.flag_written) s = {s, " flag_written"};
    if (got.flag_value !== want.flag_value) s = {s, " flag_value"};
    if (got.clear_screen !== want.clear_screen) s = {s, " clear_screen"};
    if (got.status !== want.status) s = {s, " status"};
    return s;
  endfunction

  function automatic string show_effect(vm_effect_t e);
    return $sformatf("pc=%h idx=%h reg=%b/%h/%h flag=%b/%b cls=%b st=%0d",
                     e.next_pc, e.index_value, e.reg_written, e.reg_number,
                     e.reg_value, e.flag_written, e.flag_value, e.clear_screen,
                     e.status);
  endfunction

  // Offer one instruction word from the falling edge and hold it until taken.
  // Valid stays high into the next word unless a gap is drawn.
  task automatic send_word(input logic [OP_W-1:0] op,
                           input logic [BYTE_W-1:0] rnd);
    vm_effect_t eff;
    @(negedge clk);
    if (gaps_enabled && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.random_byte <= rnd;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    execute_instruction(op, rnd, eff);
    pending_effects.push_back(eff);
  endtask

  // Drop valid, wait for every predicted word, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_effects.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Load the start address; the block must be idle. The PC follows at once.
  task automatic write_start(input logic [ADDR_W-1:0] addr);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(negedge clk);
    cfg_we <= 1'b0;
    vm_pc  = addr;
  endtask

  // Extremes of the fields and every operation but call and return, including the flag corner
  // cases, x = 15 on the ALU, wrap of skips and of jump-plus-V0
  task automatic test_directed_ops();
    send_word(OP_CLS, 8'h00);
    send_word({GRP_SYS, 12'h123}, 8'hFF);
    send_word({GRP_LDI, 4'hA, 8'hFF}, 8'h00);
    send_word({GRP_LDI, 4'hB, 8'h01}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_ADD}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_SUB}, 8'h00);
    send_word({GRP_ALU, 4'hB, 4'hA, ALU_SBN}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hA, ALU_SUB}, 8'h00);
    send_word({GRP_LDI, 4'hA, 8'h81}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_SHR}, 8'h00);
    send_word({GRP_ALU, 4'hB, 4'h3, ALU_SHL}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_OR}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_AND}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_XOR}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_MOV}, 8'h00);
    send_word({GRP_ALU, FLAG_REG, 4'hB, ALU_ADD}, 8'h00);
    send_word({GRP_ALU, 4'hA, 4'hB, ALU_BAD}, 8'h00);
    send_word({GRP_ADDI, 4'hA, 8'hFF}, 8'h00);
    send_word({GRP_SEQI, 4'hA, vm_gp[4'hA]}, 8'h00);
    send_word({GRP_SNEI, 4'hA, vm_gp[4'hA]}, 8'h00);
    send_word({GRP_SEQR, 4'hA, 4'hA, 4'h0}, 8'h00);
    send_word({GRP_SEQR, 4'hA, 4'hB, 4'h1}, 8'h00);
    send_word({GRP_SNER, 4'hA, 4'hB, 4'h0}, 8'h00);
    send_word({GRP_SNER, 4'hA, 4'hB, 4'hF}, 8'h00);
    send_word({GRP_SETI, 12'hFFF}, 8'h00);
    send_word({GRP_LDI, 4'h0, 8'hFF}, 8'h00);
    send_word({GRP_JPV0, 12'hFFF}, 8'h00);
    send_word({GRP_RND, 4'hC, 8'hFF}, 8'hA5);
    send_word({GRP_RND, 4'hC, 8'h5A}, 8'hFF);
    // land at the top of memory, then skip across the wrap
    send_word({GRP_JP, 12'hFFE}, 8'h00);
    send_word({GRP_SEQI, 4'hC, vm_gp[4'hC]}, 8'h00);
    send_word({GRP_DRAW, 12'h123}, 8'h00);
    send_word({GRP_KEY, 12'h19E}, 8'h00);
    send_word({GRP_MISC, 12'hFFF}, 8'hFF);
    send_word({GRP_SYS, 12'h000}, 8'h00);
    wait_idle();
  endtask

  // Fill the return stack, call once more, unwind it, return once more
  task automatic test_stack_limits();
    repeat (STACK_DEPTH) send_word({GRP_CALL, 12'($urandom)}, 8'($urandom));
    send_word({GRP_CALL, 12'($urandom)}, 8'($urandom));
    repeat (STACK_DEPTH) send_word(OP_RET, 8'($urandom));
    send_word(OP_RET, 8'($urandom));
    wait_idle();
  endtask

  // Sweep the start address through its extremes and back to the reset value
  task automatic test_start_address();
    logic [ADDR_W-1:0] starts [5];
    starts[0] = '0;
    starts[1] = 12'hFFF;
    starts[2] = 12'hFFE;
    starts[3] = 12'($urandom);
    starts[4] = PC_RESET;
    foreach (starts[i]) begin
      write_start(starts[i]);
      send_word({GRP_SEQI, 4'h0, vm_gp[0]}, 8'($urandom));
      repeat (6) send_word(pick_instruction(), 8'($urandom));
    end
    wait_idle();
  endtask

  task automatic test_random_program();
    repeat (RANDOM_WORDS) send_word(pick_instruction(), 8'($urandom));
    wait_idle();
  endtask

  // Hold off the result side long enough that the input stalls
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (HOLD_WORDS) send_word(pick_instruction(), 8'($urandom));
    wait_idle();
  endtask

  // Back-to-back words with both sides always willing
  task automatic test_steady_stream();
    gaps_enabled = 1'b0;
    repeat (STEADY_WORDS) send_word(pick_instruction(), 8'($urandom));
    wait_idle();
  endtask

  // Result-side readiness: random short stalls, or one long hold on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (gaps_enabled && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result word taken with the oldest prediction
  always @(posedge clk) begin
    vm_effect_t got, want;
    string      bad;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{next_pc: out_if.next_pc, index_value: out_if.index_value,
              reg_written: out_if.reg_written, reg_number: out_if.reg_number,
              reg_value: out_if.reg_value, flag_written: out_if.flag_written,
              flag_value: out_if.flag_value, clear_screen: out_if.clear_screen,
              status: status_t'(out_if.status)};
      if (pending_effects.size() == 0) begin
        want = '0;
        bad  = " unexpected word";
      end else begin
        want = pending_effects.pop_front();
        bad  = field_diff(want, got);
      end
      if (bad != "") begin
        if (mismatch_count < REPORT_LIMIT)
          $display("word %0d differs in%s: expected %s, got %s", words_checked,
                   bad, show_effect(want), show_effect(got));
        mismatch_count++;
      end
      words_checked++;
    end
  end

  // Abort if neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.opcode      = '0;
    in_if.random_byte = '0;
    gaps_enabled      = 1'b1;
    hold_req          = 1'b0;
    mismatch_count    = 0;
    words_checked     = 0;
    quiet_cycles      = 0;
    foreach (vm_gp[i]) vm_gp[i] = '0;
    vm_index = '0;
    vm_pc    = PC_RESET;
    vm_depth = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_ops();
    test_stack_limits();
    test_start_address();
    test_random_program();
    test_backpressure();
    test_steady_stream();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
